/* rtl/core/tch_pkg.sv */
// ----------------------------------------------------------------------------
// tch_pkg
// Shared constants, types and tables of the tilt-compensated heading core.
// ----------------------------------------------------------------------------
package tch_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int INTERNAL_BITS = 24;
    localparam int CORDIC_RUN    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    // Integer square root of a 32-bit word: one result bit per cell.
    localparam int SQ_STEPS = 16;
    // Width of the tilt products and of the horizontal vector.
    localparam int PW       = 54;
    // CORDIC datapath width; the vector enters below 2^(INTERNAL_BITS-3).
    localparam int CW       = INTERNAL_BITS + 2;
    localparam int LIM_BIT  = INTERNAL_BITS - 4;
    localparam int PIDX_W   = $clog2(PW);

    localparam logic [15:0] HEAD_TURN = 16'd36000;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_OFFSET_X = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z = 2'd2;

    // Per-item data that rides along the square-root cells.
    typedef struct packed {
        logic               rdy;
        logic               azero;
        logic signed [16:0] mx;
        logic signed [16:0] my;
        logic signed [16:0] mz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } sq_side_t;

    // Per-item data that rides along the tilt product stages.
    typedef struct packed {
        logic               rdy;
        logic               azero;
        logic               qzero;
        logic               axpos;
        logic signed [16:0] mx;
        logic signed [16:0] my;
        logic signed [16:0] mz;
    } tl_side_t;

    // Per-item flags that ride along the CORDIC cells.
    typedef struct packed {
        logic force0;
        logic tilt;
        logic status;
    } cr_side_t;

    // arctan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

/* rtl/core/tch_in_if.sv */
// ----------------------------------------------------------------------------
// tch_in_if
// Sample channel: magnetometer and accelerometer beat with valid/ready.
// ----------------------------------------------------------------------------
interface tch_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               data_ready;

    modport source (output valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                    data_ready, input ready);
    modport sink   (input valid, mag_x, mag_y, mag_z, accel_x, accel_y, accel_z,
                    data_ready, output ready);
endinterface

/* rtl/core/tch_out_if.sv */
// ----------------------------------------------------------------------------
// tch_out_if
// Result channel: heading beat with valid/ready.
// ----------------------------------------------------------------------------
interface tch_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;
    logic        status;
    logic        tilt_used;

    modport source (output valid, heading, status, tilt_used, input ready);
    modport sink   (input valid, heading, status, tilt_used, output ready);
endinterface

/* rtl/core/tch_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tch_sqrt_cell
// One restoring step of a 32-bit integer square root, registered.
// ----------------------------------------------------------------------------
module tch_sqrt_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [3:0]  step,
    input  logic [31:0] v_in,
    input  logic [31:0] r_in,
    output logic [31:0] v_reg,
    output logic [31:0] r_reg
);
    logic [31:0] b_val;
    logic [32:0] t_val;
    logic [31:0] v_next;
    logic [31:0] r_next;

    always_comb
    begin
        b_val = 32'h4000_0000 >> {step, 1'b0};
        t_val = {1'b0, r_in} + {1'b0, b_val};
        if ({1'b0, v_in} >= t_val)
        begin
            v_next = v_in - t_val[31:0];
            r_next = (r_in >> 1) + b_val;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            r_reg <= r_next;
        end
    end
endmodule

/* rtl/core/tch_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tch_cordic_cell
// One vectoring CORDIC micro-rotation with phase accumulation, registered.
// ----------------------------------------------------------------------------
module tch_cordic_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [4:0]                    step,
    input  logic signed [tch_pkg::CW-1:0] x_in,
    input  logic signed [tch_pkg::CW-1:0] y_in,
    input  logic [31:0]                   z_in,
    output logic signed [tch_pkg::CW-1:0] x_reg,
    output logic signed [tch_pkg::CW-1:0] y_reg,
    output logic [31:0]                   z_reg
);
    import tch_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [31:0]          ang;

    always_comb
    begin
        dx  = y_in >>> step;
        dy  = x_in >>> step;
        ang = atan_turn(step);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in > 0)
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + ang;
            end
            else
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - ang;
            end
        end
    end
endmodule

/* rtl/core/tilt_compensated_heading_core.sv */
// ----------------------------------------------------------------------------
// tilt_compensated_heading_core
// Tilt-compensated compass heading in hundredths of a degree.
// ----------------------------------------------------------------------------
// The core takes one sample beat per clock unless the result side stalls,
// and returns one heading beat per sample, in order. The pipeline is made of
// two cell chains: sixteen square root cells for each accelerometer magnitude
// and sixteen CORDIC cells for the final angle, plus twelve stages for offsets,
// tilt products, scaling and the degree conversion. A stall on the result side
// holds the whole pipeline. Hard-iron offsets are written over the APB port at
// 0x0, 0x4 and 0x8 and should only change while no sample is in flight.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_core (
    input  logic                         clk,
    input  logic                         rst_n,
    tch_in_if.sink                       sample,
    tch_out_if.source                    result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tch_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import tch_pkg::*;

    localparam int NSTG = 2 + SQ_STEPS + 8 + CORDIC_RUN + 2;
    localparam logic [PIDX_W-1:0] LIM_P = PIDX_W'(LIM_BIT);

    logic en;
    logic [NSTG-1:0] vld_reg;

    // ---------------- configuration ----------------
    logic signed [15:0] off_x_reg;
    logic signed [15:0] off_y_reg;
    logic signed [15:0] off_z_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_OFFSET_X: off_x_reg <= pwdata[15:0];
                REG_OFFSET_Y: off_y_reg <= pwdata[15:0];
                REG_OFFSET_Z: off_z_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OFFSET_X: prdata = {{16{off_x_reg[15]}}, off_x_reg};
            REG_OFFSET_Y: prdata = {{16{off_y_reg[15]}}, off_y_reg};
            REG_OFFSET_Z: prdata = {{16{off_z_reg[15]}}, off_z_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign en           = !vld_reg[NSTG-1] || result.ready;
    assign sample.ready = en;
    assign result.valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], sample.valid};
    end

    // ---------------- S0: offsets ----------------
    sq_side_t s0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg.rdy   <= sample.data_ready;
            s0_reg.azero <= (sample.accel_x == 16'sd0) && (sample.accel_y == 16'sd0)
                            && (sample.accel_z == 16'sd0);
            s0_reg.mx    <= 17'(sample.mag_x) - 17'(off_x_reg);
            s0_reg.my    <= 17'(sample.mag_y) - 17'(off_y_reg);
            s0_reg.mz    <= 17'(sample.mag_z) - 17'(off_z_reg);
            s0_reg.ax    <= sample.accel_x;
            s0_reg.ay    <= sample.accel_y;
            s0_reg.az    <= sample.accel_z;
        end
    end

    // ---------------- S1: squared magnitudes ----------------
    sq_side_t    s1_reg;
    logic [31:0] q2_reg;
    logic [31:0] n2_reg;
    logic [31:0] sqx;
    logic [31:0] sqy;
    logic [31:0] sqz;

    always_comb
    begin
        sqx = 32'(s0_reg.ax * s0_reg.ax);
        sqy = 32'(s0_reg.ay * s0_reg.ay);
        sqz = 32'(s0_reg.az * s0_reg.az);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s0_reg;
            q2_reg <= sqy + sqz;
            n2_reg <= sqy + sqz + sqx;
        end
    end

    // ---------------- square root cells ----------------
    logic [31:0] qv [SQ_STEPS];
    logic [31:0] qr [SQ_STEPS];
    logic [31:0] nv [SQ_STEPS];
    logic [31:0] nr [SQ_STEPS];
    sq_side_t    sq_side_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        tch_sqrt_cell u_q (
            .clk   (clk),
            .en    (en),
            .step  (4'(k)),
            .v_in  ((k == 0) ? q2_reg : qv[(k == 0) ? 0 : k - 1]),
            .r_in  ((k == 0) ? 32'd0  : qr[(k == 0) ? 0 : k - 1]),
            .v_reg (qv[k]),
            .r_reg (qr[k])
        );
        tch_sqrt_cell u_n (
            .clk   (clk),
            .en    (en),
            .step  (4'(k)),
            .v_in  ((k == 0) ? n2_reg : nv[(k == 0) ? 0 : k - 1]),
            .r_in  ((k == 0) ? 32'd0  : nr[(k == 0) ? 0 : k - 1]),
            .v_reg (nv[k]),
            .r_reg (nr[k])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                sq_side_reg[k] <= (k == 0) ? s1_reg : sq_side_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // ---------------- P1..P4: tilt products ----------------
    sq_side_t           sq_o;
    logic signed [16:0] q_s;
    logic signed [16:0] n_s;
    logic signed [16:0] abs_az;

    assign sq_o   = sq_side_reg[SQ_STEPS-1];
    assign q_s    = {1'b0, qr[SQ_STEPS-1][15:0]};
    assign n_s    = {1'b0, nr[SQ_STEPS-1][15:0]};
    assign abs_az = sq_o.az[15] ? -17'(sq_o.az) : 17'(sq_o.az);

    tl_side_t           p1_side_reg, p2_side_reg, p3_side_reg;
    logic signed [15:0] p1_ax_reg, p2_ax_reg;
    logic signed [16:0] p1_q_reg, p1_n_reg, p2_q_reg, p2_n_reg;
    logic signed [33:0] p1_a_reg, p1_b_reg, p1_c_reg, p1_d_reg, p1_e_reg;
    logic signed [34:0] p2_f_reg;
    logic signed [33:0] p2_c_reg, p2_d_reg, p2_e_reg;
    logic signed [PW-1:0] p3_x_reg, p3_y1_reg, p3_y2_reg, p3_y3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_side_reg.rdy   <= sq_o.rdy;
            p1_side_reg.azero <= sq_o.azero;
            p1_side_reg.qzero <= (q_s == 17'sd0);
            p1_side_reg.axpos <= (sq_o.ax > 16'sd0);
            p1_side_reg.mx    <= sq_o.mx;
            p1_side_reg.my    <= sq_o.my;
            p1_side_reg.mz    <= sq_o.mz;
            p1_ax_reg <= sq_o.ax;
            p1_q_reg  <= q_s;
            p1_n_reg  <= n_s;
            p1_a_reg  <= sq_o.mx * q_s;
            p1_b_reg  <= sq_o.mz * 17'(sq_o.ax);
            p1_c_reg  <= sq_o.mx * 17'(sq_o.ay);
            p1_d_reg  <= sq_o.my * abs_az;
            p1_e_reg  <= sq_o.mz * 17'(sq_o.ay);

            p2_side_reg <= p1_side_reg;
            p2_ax_reg   <= p1_ax_reg;
            p2_q_reg    <= p1_q_reg;
            p2_n_reg    <= p1_n_reg;
            p2_f_reg    <= 35'(p1_a_reg) - 35'(p1_b_reg);
            p2_c_reg    <= p1_c_reg;
            p2_d_reg    <= p1_d_reg;
            p2_e_reg    <= p1_e_reg;

            p3_side_reg <= p2_side_reg;
            p3_x_reg    <= PW'(p2_f_reg * 35'(p2_q_reg));
            p3_y1_reg   <= PW'(p2_c_reg * 34'(p2_ax_reg));
            p3_y2_reg   <= PW'(p2_d_reg * 34'(p2_n_reg));
            p3_y3_reg   <= PW'(p2_e_reg * 34'(p2_q_reg));
        end
    end

    // P4: sum and special cases.
    cr_side_t             p4_side_reg;
    logic signed [PW-1:0] p4_x_reg, p4_y_reg;
    logic signed [PW-1:0] x4_next, y4_next;

    always_comb
    begin
        priority if (p3_side_reg.azero)
        begin
            x4_next = PW'(p3_side_reg.mx);
            y4_next = PW'(p3_side_reg.my);
        end
        else if (p3_side_reg.qzero)
        begin
            // Pitch at ninety degrees: roll is taken as zero.
            x4_next = p3_side_reg.axpos ? -PW'(p3_side_reg.mz) : PW'(p3_side_reg.mz);
            y4_next = PW'(p3_side_reg.my);
        end
        else
        begin
            x4_next = p3_x_reg;
            y4_next = p3_y2_reg - p3_y1_reg - p3_y3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_side_reg.force0 <= !p3_side_reg.rdy;
            p4_side_reg.tilt   <= p3_side_reg.rdy && !p3_side_reg.azero;
            p4_side_reg.status <= !p3_side_reg.rdy;
            p4_x_reg <= x4_next;
            p4_y_reg <= y4_next;
        end
    end

    // ---------------- P5..P8: scaling ----------------
    cr_side_t             p5_side_reg, p6_side_reg, p7_side_reg, p8_side_reg;
    logic [PW-1:0]        p5_m_reg;
    logic signed [PW-1:0] p5_x_reg, p5_y_reg, p6_x_reg, p6_y_reg;
    logic [PIDX_W-1:0]    p6_p_reg;
    logic [PIDX_W-1:0]    p_next;
    logic signed [PW-1:0] xs_next, ys_next;
    logic signed [CW-1:0] p7_x_reg, p7_y_reg, p8_x_reg, p8_y_reg;
    logic [31:0]          p8_z_reg;
    logic [PW-1:0]        abs_x, abs_y;

    assign abs_x = p4_x_reg[PW-1] ? PW'(-p4_x_reg) : PW'(p4_x_reg);
    assign abs_y = p4_y_reg[PW-1] ? PW'(-p4_y_reg) : PW'(p4_y_reg);

    // The highest set bit of the OR of both magnitudes is that of the larger one.
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (p5_m_reg[i])
                p_next = PIDX_W'(i);
        end
    end

    always_comb
    begin
        if (p6_p_reg > LIM_P)
        begin
            xs_next = p6_x_reg >>> (p6_p_reg - LIM_P);
            ys_next = p6_y_reg >>> (p6_p_reg - LIM_P);
        end
        else
        begin
            xs_next = p6_x_reg <<< (LIM_P - p6_p_reg);
            ys_next = p6_y_reg <<< (LIM_P - p6_p_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_side_reg <= p4_side_reg;
            p5_m_reg    <= abs_x | abs_y;
            p5_x_reg    <= p4_x_reg;
            p5_y_reg    <= p4_y_reg;

            // A zero horizontal vector reads as heading zero.
            p6_side_reg.force0 <= p5_side_reg.force0 || (p5_m_reg == '0);
            p6_side_reg.tilt   <= p5_side_reg.tilt;
            p6_side_reg.status <= p5_side_reg.status;
            p6_p_reg           <= p_next;
            p6_x_reg           <= p5_x_reg;
            p6_y_reg           <= p5_y_reg;

            p7_side_reg <= p6_side_reg;
            p7_x_reg    <= xs_next[CW-1:0];
            p7_y_reg    <= ys_next[CW-1:0];

            // Fold into the right half plane.
            p8_side_reg <= p7_side_reg;
            if (p7_x_reg < 0)
            begin
                p8_x_reg <= -p7_x_reg;
                p8_y_reg <= -p7_y_reg;
                p8_z_reg <= HALF_TURN;
            end
            else
            begin
                p8_x_reg <= p7_x_reg;
                p8_y_reg <= p7_y_reg;
                p8_z_reg <= '0;
            end
        end
    end

    // ---------------- CORDIC cells ----------------
    logic signed [CW-1:0] cx [CORDIC_RUN];
    logic signed [CW-1:0] cy [CORDIC_RUN];
    logic [31:0]          cz [CORDIC_RUN];
    cr_side_t             cr_side_reg [CORDIC_RUN];

    for (genvar k = 0; k < CORDIC_RUN; k++)
    begin : g_cordic
        tch_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .step  (5'(k)),
            .x_in  ((k == 0) ? p8_x_reg : cx[(k == 0) ? 0 : k - 1]),
            .y_in  ((k == 0) ? p8_y_reg : cy[(k == 0) ? 0 : k - 1]),
            .z_in  ((k == 0) ? p8_z_reg : cz[(k == 0) ? 0 : k - 1]),
            .x_reg (cx[k]),
            .y_reg (cy[k]),
            .z_reg (cz[k])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                cr_side_reg[k] <= (k == 0) ? p8_side_reg : cr_side_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // ---------------- degree conversion and result register ----------------
    cr_side_t    h1_side_reg;
    logic [15:0] h1_h_reg;
    logic [47:0] prod;
    logic [15:0] heading_reg;
    logic        status_reg;
    logic        tilt_reg;

    assign prod = {16'd0, cz[CORDIC_RUN-1]} * {32'd0, HEAD_TURN} + {16'd0, HALF_TURN};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_side_reg <= cr_side_reg[CORDIC_RUN-1];
            h1_h_reg    <= prod[47:32];
            if (h1_side_reg.force0 || (h1_h_reg >= HEAD_TURN))
                heading_reg <= '0;
            else
                heading_reg <= h1_h_reg;
            status_reg <= h1_side_reg.status;
            tilt_reg   <= h1_side_reg.tilt;
        end
    end

    assign result.heading   = heading_reg;
    assign result.status    = status_reg;
    assign result.tilt_used = tilt_reg;

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> vld_reg[0])
        else $error("accepted sample did not enter the pipeline");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.heading < HEAD_TURN)
        else $error("heading out of range");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.heading == 16'd0 && !result.tilt_used)
        else $error("not-ready result carries a heading or tilt flag");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");
endmodule
